// ----- design/gdrt_pkg.sv -----
package gdrt_pkg;

	localparam int TABLE_ENTRIES_DEF   = 1024;
	localparam int GENERATION_BITS_DEF = 8;
	localparam int KEY_W               = 64;
	localparam int COUNT_OUT_W         = 11;

	typedef enum logic [1:0] {
		CMD_STORE      = 2'd0,
		CMD_LOOKUP     = 2'd1,
		CMD_NEW_SEARCH = 2'd2,
		CMD_CLEAR      = 2'd3
	} mode_t;

	typedef struct packed {
		logic        [2:0]  col;
		logic        [2:0]  row;
		logic               move_present;
		logic        [1:0]  kind;
		logic        [5:0]  depth;
		logic signed [15:0] score;
	} payload_t;

	localparam int PAYLOAD_W = $bits(payload_t);

	typedef struct packed {
		logic     we;
		logic     inc;
		logic     hit;
		payload_t wr_payload;
		payload_t hit_payload;
	} upd_t;

endpackage

// ----- design/gdrt_ram.sv -----
module gdrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/gdrt_update.sv -----
module gdrt_update #(
	parameter int GENERATION_BITS = gdrt_pkg::GENERATION_BITS_DEF
) (
	input  gdrt_pkg::mode_t              mode,
	input  logic [gdrt_pkg::KEY_W-1:0]   key,
	input  gdrt_pkg::payload_t           new_payload,
	input  logic [GENERATION_BITS-1:0]   cur_gen,
	input  logic                         e_valid,
	input  logic [GENERATION_BITS-1:0]   e_gen,
	input  logic [gdrt_pkg::KEY_W-1:0]   e_key,
	input  gdrt_pkg::payload_t           e_payload,
	output gdrt_pkg::upd_t               upd
);

	import gdrt_pkg::*;

	logic match;
	logic deeper;
	logic replace;

	always_comb begin
		match   = e_valid && (e_key == key);
		deeper  = new_payload.depth >= e_payload.depth;
		replace = !e_valid || match || (e_gen != cur_gen) || deeper;

		upd.we          = (mode == CMD_STORE) && replace;
		upd.inc         = (mode == CMD_STORE) && !e_valid;
		upd.hit         = (mode == CMD_LOOKUP) && match;
		upd.wr_payload  = (match && !deeper) ? e_payload : new_payload;
		upd.hit_payload = upd.hit ? e_payload : '0;
	end

endmodule

// ----- design/generation_depth_replacement_table_unit.sv -----
// The slot is read from the table memory on acceptance and written back in the
// next cycle, when the result is formed; the result is registered and then
// moved to the output register once that register is free or being taken.
// A new transaction is not accepted until the previous result has moved to the output register.
// Clear, and a new search that wraps the generation, sweep the table memory
// one entry per cycle, through every entry, before the next acceptance.
// After reset the same sweep runs before input is taken.
module generation_depth_replacement_table_unit #(
	parameter int TABLE_ENTRIES   = gdrt_pkg::TABLE_ENTRIES_DEF,
	parameter int GENERATION_BITS = gdrt_pkg::GENERATION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// key_hash[63:0], score[79:64], search_depth[85:80], bound_kind[87:86],
	// move_present[88], move_row[91:89], move_col[94:92], zero fill above.
	input  logic [95:0] s_axis_tdata,
	// mode[1:0].
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hit_score[15:0], hit_depth[21:16], hit_kind[23:22], hit_move_present[24],
	// hit_row[27:25], hit_col[30:28], occupied_count[41:31], zero fill above.
	output logic [47:0] m_axis_tdata,
	// hit[0].
	output logic [0:0]  m_axis_tuser
);

	import gdrt_pkg::*;

	localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_W = 1 + GENERATION_BITS + KEY_W + PAYLOAD_W;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_CLEAR
	} state_t;

	state_t                     state_q;
	logic [IDX_W-1:0]           sweep_q;
	logic [GENERATION_BITS-1:0] gen_q;
	logic [CNT_W-1:0]           count_q;
	logic                       res_valid_q;
	logic                       res_hit_q;
	payload_t                   res_pay_q;
	logic [CNT_W-1:0]           res_count_q;
	logic                       m_valid_q;
	logic [47:0]                m_data_q;
	logic                       m_hit_q;

	mode_t                      mode_s1;
	logic [KEY_W-1:0]           key_s1;
	payload_t                   pay_s1;
	logic [IDX_W-1:0]           idx_s1;

	logic                       accept;
	logic [KEY_W-1:0]           in_key;
	payload_t                   in_pay;
	logic [ENTRY_W-1:0]         rd_word;
	logic [ENTRY_W-1:0]         wr_word;
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic                       e_valid;
	logic [GENERATION_BITS-1:0] e_gen;
	logic [KEY_W-1:0]           e_key;
	payload_t                   e_payload;
	upd_t                       upd;
	logic [GENERATION_BITS-1:0] gen_inc;
	logic                       wipe;
	logic [CNT_W-1:0]           count_next;
	logic                       move_out;

	assign s_axis_tready = (state_q == ST_IDLE) && !res_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_key             = s_axis_tdata[63:0];
		in_pay.score       = s_axis_tdata[79:64];
		in_pay.depth       = s_axis_tdata[85:80];
		in_pay.kind        = s_axis_tdata[87:86];
		in_pay.move_present = s_axis_tdata[88];
		in_pay.row         = s_axis_tdata[88] ? s_axis_tdata[91:89] : 3'd0;
		in_pay.col         = s_axis_tdata[88] ? s_axis_tdata[94:92] : 3'd0;
	end

	assign {e_valid, e_gen, e_key, e_payload} = rd_word;

	gdrt_update #(
		.GENERATION_BITS(GENERATION_BITS)
	) u_update (
		.mode       (mode_s1),
		.key        (key_s1),
		.new_payload(pay_s1),
		.cur_gen    (gen_q),
		.e_valid    (e_valid),
		.e_gen      (e_gen),
		.e_key      (e_key),
		.e_payload  (e_payload),
		.upd        (upd)
	);

	always_comb begin
		gen_inc = gen_q + 1'b1;
		wipe    = (mode_s1 == CMD_CLEAR) ||
		          ((mode_s1 == CMD_NEW_SEARCH) && (gen_inc == '0));
		if (wipe) begin
			count_next = '0;
		end else if (upd.inc) begin
			count_next = count_q + 1'b1;
		end else begin
			count_next = count_q;
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			wr_word   = '0;
		end else begin
			ram_we    = (state_q == ST_LOOKUP) && upd.we;
			ram_waddr = idx_s1;
			wr_word   = {1'b1, gen_q, key_s1, upd.wr_payload};
		end
	end

	gdrt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_word),
		.re   (accept),
		.raddr(in_key[IDX_W-1:0] & IDX_MASK),
		.rdata(rd_word)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= in_key;
			pay_s1 <= in_pay;
			idx_s1 <= in_key[IDX_W-1:0] & IDX_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			gen_q       <= GENERATION_BITS'(1);
			count_q     <= '0;
			mode_s1     <= CMD_STORE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_s1 <= mode_t'(s_axis_tuser);
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					count_q     <= count_next;
					res_valid_q <= 1'b1;
					if (wipe) begin
						gen_q   <= GENERATION_BITS'(1);
						sweep_q <= '0;
						state_q <= ST_CLEAR;
					end else begin
						if (mode_s1 == CMD_NEW_SEARCH) begin
							gen_q <= gen_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == IDX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (move_out) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			res_hit_q   <= upd.hit;
			res_pay_q   <= upd.hit_payload;
			res_count_q <= count_next;
		end
	end

	assign move_out = res_valid_q && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (move_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			m_hit_q  <= res_hit_q;
			m_data_q <= {6'd0, COUNT_OUT_W'(res_count_q), res_pay_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_hit_q;

`ifndef NO_ASSERTIONS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOOKUP))
		else $error("accepted transaction did not enter the lookup state");

	a_result_formed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |=> res_valid_q)
		else $error("lookup state did not produce a result");

	a_store_only_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == ST_LOOKUP)) |-> (mode_s1 == CMD_STORE))
		else $error("table written by a command other than store");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("occupied count exceeds the table size");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("input taken during the clearing sweep");
`endif

endmodule
